// ----- sv/pmp_pkg.sv -----
// Shared definitions for the physical memory protection checker.
// Holds field codes, default sizes and the item and token structures.
// No dependencies.
package pmp_pkg;

  localparam int ENTRIES_DEF         = 16;
  localparam int ENTRY_ADDR_BITS_DEF = 54;

  // Cycles a write item keeps the block busy while the region registers settle.
  localparam int WRITE_SETTLE = 2;

  localparam logic       FUNC_WRITE = 1'b0;
  localparam logic       FUNC_CHECK = 1'b1;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_TOR   = 2'd1;
  localparam logic [1:0] MODE_NA4   = 2'd2;
  localparam logic [1:0] MODE_NAPOT = 2'd3;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_AMO   = 2'd2;
  localparam logic [1:0] KIND_FETCH = 2'd3;

  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  localparam int CFG_R_BIT    = 0;
  localparam int CFG_W_BIT    = 1;
  localparam int CFG_X_BIT    = 2;
  localparam int CFG_MODE_LO  = 3;
  localparam int CFG_LOCK_BIT = 7;

  // The access under check, broadcast to every cell while the item is busy.
  typedef struct packed {
    logic [63:0] addr;
    logic [63:0] aend;
    logic        need_r;
    logic        need_w;
    logic        need_x;
    logic        machine;
  } access_t;

  // The decision token that walks down the row of cells.
  typedef struct packed {
    logic valid;
    logic decided;
    logic allow;
  } token_t;

endpackage

// ----- sv/pmp_cell.sv -----
// One protection entry: its config byte, its address, the decoded region and
// one stage of the decision token. Depends on pmp_pkg.
module pmp_cell
  import pmp_pkg::*;
#(
  parameter int ENTRY_ADDR_BITS = ENTRY_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [7:0]                 wr_cfg,
  input  logic [ENTRY_ADDR_BITS-1:0] wr_addr,
  input  logic [ENTRY_ADDR_BITS-1:0] prev_addr,
  output logic [ENTRY_ADDR_BITS-1:0] addr_out,
  input  access_t                    acc,
  input  token_t                     tok_in,
  output token_t                     tok_out
);

  localparam int AW = ENTRY_ADDR_BITS;

  logic [7:0]    cfg_r;
  logic [AW-1:0] addr_r;

  // First region stage: base word, span in words, whole-space flag.
  logic          valid_a_r, valid_a_nxt;
  logic          whole_a_r, whole_a_nxt;
  logic [AW-1:0] base_w_a_r, base_w_a_nxt;
  logic [AW:0]   inc_a_r, inc_a_nxt;

  // Second region stage: byte bounds, the end exact up to 2^64.
  logic          valid_b_r, valid_b_nxt;
  logic [63:0]   base_b_r, base_b_nxt;
  logic [64:0]   end_b_r, end_b_nxt;

  token_t        tok_r, tok_nxt;

  logic [1:0]    mode;
  logic [AW-1:0] lo_w, hi_w;
  logic [AW:0]   a_inc;
  logic [AW-1:0] t_ones, low_zero;
  logic [AW+1:0] end_w;
  logic          match, covered, perm_ok, allow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= '0;
      addr_r <= '0;
    end else if (wr_en) begin
      cfg_r  <= wr_cfg;
      addr_r <= wr_addr;
    end
  end

  assign addr_out = addr_r;

  assign mode     = cfg_r[CFG_MODE_LO +: 2];
  assign lo_w     = prev_addr & ~AW'(3);
  assign hi_w     = addr_r & ~AW'(3);
  assign a_inc    = {1'b0, addr_r} + (AW+1)'(1);
  // Trailing ones of the address, and the lowest clear bit above them.
  assign t_ones   = addr_r & ~a_inc[AW-1:0];
  assign low_zero = ~addr_r & a_inc[AW-1:0];

  always_comb begin
    valid_a_nxt  = 1'b0;
    whole_a_nxt  = 1'b0;
    base_w_a_nxt = '0;
    inc_a_nxt    = '0;
    unique case (mode)
      MODE_OFF: begin
        valid_a_nxt = 1'b0;
      end
      MODE_TOR: begin
        valid_a_nxt  = hi_w > lo_w;
        base_w_a_nxt = lo_w;
        inc_a_nxt    = {1'b0, hi_w - lo_w};
      end
      MODE_NA4: begin
        valid_a_nxt  = 1'b1;
        base_w_a_nxt = addr_r;
        inc_a_nxt    = (AW+1)'(1);
      end
      MODE_NAPOT: begin
        valid_a_nxt  = 1'b1;
        whole_a_nxt  = a_inc[AW];
        base_w_a_nxt = addr_r & ~t_ones;
        inc_a_nxt    = {low_zero, 1'b0};
      end
      default: begin
        valid_a_nxt = 1'b0;
      end
    endcase
  end

  assign end_w = {1'b0, base_w_a_r} + {1'b0, inc_a_r};

  always_comb begin
    valid_b_nxt = valid_a_r;
    if (whole_a_r) begin
      base_b_nxt = '0;
      end_b_nxt  = {1'b1, 64'd0};
    end else begin
      base_b_nxt = 64'({base_w_a_r, 2'b00});
      end_b_nxt  = 65'({end_w, 2'b00});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      whole_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      valid_a_r <= valid_a_nxt;
      whole_a_r <= whole_a_nxt;
      valid_b_r <= valid_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_w_a_r <= base_w_a_nxt;
    inc_a_r    <= inc_a_nxt;
    base_b_r   <= base_b_nxt;
    end_b_r    <= end_b_nxt;
  end

  // The access end wraps, so the overlap test uses it exactly as it stands.
  assign match   = valid_b_r && ({1'b0, acc.addr} < end_b_r) && (acc.aend > base_b_r);
  assign covered = (acc.addr >= base_b_r) && ({1'b0, acc.aend} <= end_b_r);

  assign perm_ok = !((acc.need_r && !cfg_r[CFG_R_BIT]) ||
                     (acc.need_w && !cfg_r[CFG_W_BIT]) ||
                     (acc.need_x && !cfg_r[CFG_X_BIT]));
  assign allow   = covered && ((acc.machine && !cfg_r[CFG_LOCK_BIT]) || perm_ok);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.decided && match) begin
      tok_nxt.decided = 1'b1;
      tok_nxt.allow   = allow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- sv/pmp_access_checker.sv -----
// Top level of the physical memory protection checker: control, access
// register and the row of pmp_cell entries. Depends on pmp_pkg and pmp_cell.
//
// Usage. An item is taken at a rising edge with start high and busy low.
// A write item (in_func 0) loads entry in_entry_index with in_entry_cfg and
// in_entry_addr; indexes past the table are ignored; it gives no result and
// keeps busy high while the decoded regions settle.
// A check item (in_func 1) tests in_access_addr .. +in_access_len against the
// entries. A decision token walks the row of cells, one entry per cycle, so
// the lowest matching entry decides. The allow bit appears on out_allowed,
// marked by out_strobe for exactly one cycle, once the token has passed the
// launch register, every cell and the output register; busy falls in that
// same cycle, so the next item is taken at the edge that ends the result cycle.
// The length of the row of cells sets how long a check item takes.
// The receiver cannot stall: the result is on the ports for that one cycle.
// Reset (rst_n low, synchronous) clears every entry to mode off and empties
// the row; the block is ready in the first cycle after reset.
module pmp_access_checker
  import pmp_pkg::*;
#(
  parameter int ENTRIES         = ENTRIES_DEF,
  parameter int ENTRY_ADDR_BITS = ENTRY_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [3:0]  in_entry_index,
  input  logic [7:0]  in_entry_cfg,
  input  logic [53:0] in_entry_addr,
  input  logic [63:0] in_access_addr,
  input  logic [3:0]  in_access_len,
  input  logic [1:0]  in_access_kind,
  input  logic [1:0]  in_privilege,
  output logic        out_strobe,
  output logic        out_allowed
);

  localparam int AW    = ENTRY_ADDR_BITS;
  localparam int CNT_W = $clog2(ENTRIES + 2);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             launch_r;
  access_t          acc_r;
  logic             out_strobe_r;
  logic             out_allowed_r;

  logic             accept, wr_accept, chk_accept;
  logic [63:0]      wr_addr_ext;
  logic [AW-1:0]    wr_addr;

  token_t           tok [ENTRIES+1];
  logic [AW-1:0]    addr_chain [ENTRIES];
  logic [ENTRIES:0] tok_valid_vec;

  assign busy       = cnt_r != '0;
  assign accept     = start && !busy;
  assign wr_accept  = accept && (in_func == FUNC_WRITE);
  assign chk_accept = accept && (in_func == FUNC_CHECK);

  assign wr_addr_ext = 64'(in_entry_addr);
  assign wr_addr     = wr_addr_ext[AW-1:0];

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (wr_accept) begin
      cnt_nxt = CNT_W'(WRITE_SETTLE);
    end else if (chk_accept) begin
      cnt_nxt = CNT_W'(ENTRIES + 1);
    end else if (busy) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      launch_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      launch_r     <= chk_accept;
      out_strobe_r <= tok[ENTRIES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chk_accept) begin
      acc_r.addr    <= in_access_addr;
      acc_r.aend    <= in_access_addr + 64'(in_access_len);
      acc_r.need_r  <= (in_access_kind == KIND_READ) || (in_access_kind == KIND_AMO);
      acc_r.need_w  <= (in_access_kind == KIND_WRITE) || (in_access_kind == KIND_AMO);
      acc_r.need_x  <= in_access_kind == KIND_FETCH;
      acc_r.machine <= in_privilege == PRIV_MACHINE;
    end
    // With no entry matching, only machine mode passes.
    out_allowed_r <= tok[ENTRIES].decided ? tok[ENTRIES].allow : acc_r.machine;
  end

  assign tok[0] = '{valid: launch_r, decided: 1'b0, allow: 1'b0};

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    logic [AW-1:0] prev;
    if (k == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = addr_chain[k-1];
    end

    pmp_cell #(
      .ENTRY_ADDR_BITS(ENTRY_ADDR_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_accept && ({28'd0, in_entry_index} == k)),
      .wr_cfg   (in_entry_cfg),
      .wr_addr  (wr_addr),
      .prev_addr(prev),
      .addr_out (addr_chain[k]),
      .acc      (acc_r),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1])
    );
  end

  for (genvar k = 0; k <= ENTRIES; k++) begin : g_vld
    assign tok_valid_vec[k] = tok[k].valid;
  end

  assign out_strobe  = out_strobe_r;
  assign out_allowed = out_allowed_r;

  // Only one check item is ever in the row of cells.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid_vec) <= 1)
    else $error("more than one decision token in the row");

  // A launched token reaches the output strobe after passing every cell.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    launch_r |-> ##(ENTRIES + 1) out_strobe)
    else $error("result strobe missing after a launched check");

  // The block is free again in the cycle that shows a result.
  a_free_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("busy still high while a result is shown");

  // An accepted check launches its token and holds busy.
  a_check_launch: assert property (@(posedge clk) disable iff (!rst_n)
    chk_accept |=> launch_r && busy)
    else $error("check item accepted without launch");

endmodule

// ----- dv/pmp_allow_checker.sv -----
// Checker for the protection checker: watches the item and result channels,
// keeps its own copy of the entry table and predicts each allow bit.
// Depends on pmp_pkg for field codes and table sizes.
module pmp_allow_checker
  import pmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_func,
  input  logic [3:0]  in_entry_index,
  input  logic [7:0]  in_entry_cfg,
  input  logic [53:0] in_entry_addr,
  input  logic [63:0] in_access_addr,
  input  logic [3:0]  in_access_len,
  input  logic [1:0]  in_access_kind,
  input  logic [1:0]  in_privilege,
  input  logic        out_strobe,
  input  logic        out_allowed,
  output int          mismatches,
  output int          awaited
);

  localparam int AW = ENTRY_ADDR_BITS_DEF;

  logic [7:0]    table_cfg  [ENTRIES_DEF];
  logic [AW-1:0] table_word [ENTRIES_DEF];
  logic          allow_expected [$];
  logic          want;

  // Region ends are kept in 65 bits so that an end of exactly 2^64 is exact.
  function automatic logic predict_allow(logic [63:0] addr, logic [3:0] len,
                                         logic [1:0] kind, logic [1:0] priv);
    logic [64:0]   lo_b;
    logic [64:0]   hi_b;
    logic [63:0]   aend;
    logic [AW-1:0] word;
    logic [AW-1:0] prev;
    logic [7:0]    cfg;
    logic          hit;
    logic          done;
    logic          verdict;
    logic          need_r;
    logic          need_w;
    logic          need_x;
    logic          machine;
    int            n;
    need_r  = (kind == KIND_READ) || (kind == KIND_AMO);
    need_w  = (kind == KIND_WRITE) || (kind == KIND_AMO);
    need_x  = (kind == KIND_FETCH);
    machine = (priv == PRIV_MACHINE);
    aend    = addr + 64'(len);
    verdict = machine;
    done    = 1'b0;
    for (int k = 0; k < ENTRIES_DEF; k++) begin
      if (!done) begin
        cfg  = table_cfg[k];
        word = table_word[k];
        hit  = 1'b1;
        lo_b = '0;
        hi_b = '0;
        case (cfg[CFG_MODE_LO +: 2])
          MODE_TOR: begin
            prev = (k > 0) ? table_word[k-1] : '0;
            lo_b = 65'(prev & ~AW'(3)) << 2;
            hi_b = 65'(word & ~AW'(3)) << 2;
            hit  = hi_b > lo_b;
          end
          MODE_NA4: begin
            lo_b = 65'(word) << 2;
            hi_b = lo_b + 65'd4;
          end
          MODE_NAPOT: begin
            if (&word) begin
              hi_b = 65'd1 << 64;
            end else begin
              n = 0;
              while (word[n]) n++;
              lo_b = 65'(word & ~((AW'(1) << n) - AW'(1))) << 2;
              hi_b = lo_b + (65'd1 << (n + 3));
            end
          end
          default: hit = 1'b0;
        endcase
        if (hit && {1'b0, addr} < hi_b && {1'b0, aend} > lo_b) begin
          done = 1'b1;
          if ({1'b0, addr} < lo_b || {1'b0, aend} > hi_b)
            verdict = 1'b0;
          else if (machine && !cfg[CFG_LOCK_BIT])
            verdict = 1'b1;
          else
            verdict = !((need_r && !cfg[CFG_R_BIT]) || (need_w && !cfg[CFG_W_BIT]) ||
                        (need_x && !cfg[CFG_X_BIT]));
        end
      end
    end
    return verdict;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES_DEF; k++) begin
        table_cfg[k]  = '0;
        table_word[k] = '0;
      end
      allow_expected.delete();
      mismatches = 0;
    end else begin
      // The result shown at this edge belongs to an older item than one taken here.
      if (out_strobe !== 1'b0) begin
        if (allow_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no check item waiting, allowed %b", $realtime,
                     out_allowed);
        end else begin
          want = allow_expected.pop_front();
          if (out_allowed !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: allowed mismatch, expected %b, got %b", $realtime, want,
                       out_allowed);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (in_func == FUNC_WRITE) begin
          if (in_entry_index < ENTRIES_DEF) begin
            table_cfg[in_entry_index]  = in_entry_cfg;
            table_word[in_entry_index] = AW'(in_entry_addr);
          end
        end else begin
          allow_expected.push_back(predict_allow(in_access_addr, in_access_len,
                                                 in_access_kind, in_privilege));
        end
      end
    end
    awaited = allow_expected.size();
  end

endmodule

// ----- dv/tb_pmp_access_checker.sv -----
// Testbench top for pmp_access_checker: makes directed and random items with
// random idling and gives the verdict. Depends on pmp_pkg, the block and
// pmp_allow_checker.
module tb_pmp_access_checker;
  import pmp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_func;
  logic [3:0]  in_entry_index;
  logic [7:0]  in_entry_cfg;
  logic [53:0] in_entry_addr;
  logic [63:0] in_access_addr;
  logic [3:0]  in_access_len;
  logic [1:0]  in_access_kind;
  logic [1:0]  in_privilege;
  logic        out_strobe;
  logic        out_allowed;
  int          mismatches;
  int          awaited;

  int          items_sent;
  logic        no_idle;
  logic [53:0] cluster;
  logic [53:0] last_word [ENTRIES_DEF];

  pmp_access_checker dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_entry_cfg   (in_entry_cfg),
    .in_entry_addr  (in_entry_addr),
    .in_access_addr (in_access_addr),
    .in_access_len  (in_access_len),
    .in_access_kind (in_access_kind),
    .in_privilege   (in_privilege),
    .out_strobe     (out_strobe),
    .out_allowed    (out_allowed)
  );

  pmp_allow_checker u_allow_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_entry_index (in_entry_index),
    .in_entry_cfg   (in_entry_cfg),
    .in_entry_addr  (in_entry_addr),
    .in_access_addr (in_access_addr),
    .in_access_len  (in_access_len),
    .in_access_kind (in_access_kind),
    .in_privilege   (in_privilege),
    .out_strobe     (out_strobe),
    .out_allowed    (out_allowed),
    .mismatches     (mismatches),
    .awaited        (awaited)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_500_000;
    $display("tb_pmp_access_checker failed");
    $finish;
  end

  function automatic logic [53:0] rand_word();
    return 54'({$urandom, $urandom});
  endfunction

  function automatic logic [63:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Leaves start high at the accepting edge when the next item follows at once.
  task automatic drive_item(logic func, logic [3:0] idx, logic [7:0] cfg,
                            logic [53:0] word, logic [63:0] addr, logic [3:0] len,
                            logic [1:0] kind, logic [1:0] priv);
    int gap;
    in_func        <= func;
    in_entry_index <= idx;
    in_entry_cfg   <= cfg;
    in_entry_addr  <= word;
    in_access_addr <= addr;
    in_access_len  <= len;
    in_access_kind <= kind;
    in_privilege   <= priv;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (func == FUNC_WRITE) last_word[idx] = word;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_entry(logic [3:0] idx, logic [7:0] cfg, logic [53:0] word);
    drive_item(FUNC_WRITE, idx, cfg, word, rand_addr(), 4'($urandom), 2'($urandom),
               2'($urandom));
  endtask

  task automatic check_access(logic [63:0] addr, logic [3:0] len, logic [1:0] kind,
                              logic [1:0] priv);
    drive_item(FUNC_CHECK, 4'($urandom), 8'($urandom), rand_word(), addr, len, kind, priv);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  // Entry words: random, the whole space, TOR-friendly ascending runs near a
  // cluster, or NAPOT-shaped words with a random run of trailing ones.
  function automatic logic [53:0] make_word(logic [3:0] idx);
    logic [53:0] w;
    int          n;
    case ($urandom_range(0, 9))
      0: w = rand_word();
      1: w = '1;
      2, 3, 4: w = cluster + 54'(idx) * 54'd64 + 54'($urandom_range(0, 63));
      default: begin
        n = $urandom_range(0, 24);
        w = cluster + 54'($urandom_range(0, 4095));
        w = (w & ~((54'd1 << (n + 1)) - 54'd1)) | ((54'd1 << n) - 54'd1);
      end
    endcase
    return w;
  endfunction

  function automatic logic [7:0] make_cfg();
    logic [7:0] c;
    c = 8'($urandom);
    c[CFG_MODE_LO +: 2] = ($urandom_range(0, 7) == 0) ? MODE_OFF : 2'($urandom_range(1, 3));
    c[CFG_LOCK_BIT] = ($urandom_range(0, 3) == 0);
    return c;
  endfunction

  // Access addresses mostly land on or around the edges of programmed regions.
  function automatic logic [63:0] make_access();
    logic [63:0] b;
    logic [63:0] e;
    int          m;
    b = 64'(last_word[$urandom_range(0, ENTRIES_DEF - 1)]) << 2;
    case ($urandom_range(0, 9))
      0: return rand_addr();
      1: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
      2, 3, 4, 5: return b + 64'($urandom_range(0, 32)) - 64'd16;
      6, 7, 8: begin
        m = $urandom_range(2, 27);
        e = (b | ((64'd1 << m) - 64'd1)) + 64'd1;
        return e + 64'($urandom_range(0, 16)) - 64'd12;
      end
      default: return 64'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [3:0] make_len();
    if ($urandom_range(0, 9) < 7) return 4'd1 << $urandom_range(0, 3);
    return 4'($urandom);
  endfunction

  initial begin
    int nw;
    int nc;
    logic first_phase;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_func        <= FUNC_WRITE;
    in_entry_index <= '0;
    in_entry_cfg   <= '0;
    in_entry_addr  <= '0;
    in_access_addr <= '0;
    in_access_len  <= '0;
    in_access_kind <= KIND_READ;
    in_privilege   <= '0;
    items_sent = 0;
    no_idle    = 1'b0;
    cluster    = '0;
    for (int k = 0; k < ENTRIES_DEF; k++) last_word[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: only machine mode passes.
    check_access(64'd0, 4'd8, KIND_READ, 2'd0);
    check_access('1, 4'd15, KIND_FETCH, PRIV_MACHINE);
    // TOR from zero with read and write, unused config bits set.
    write_entry(4'd0, 8'h60 | {3'd0, MODE_TOR, 3'b011}, 54'h100);
    check_access(64'h10, 4'd8, KIND_READ, 2'd0);
    check_access(64'h3F8, 4'd8, KIND_AMO, 2'd0);
    check_access(64'h20, 4'd4, KIND_FETCH, 2'd0);
    check_access(64'h20, 4'd4, KIND_FETCH, PRIV_MACHINE);
    check_access(64'h3FC, 4'd8, KIND_WRITE, 2'd1);
    // Locked NA4, execute only.
    write_entry(4'd1, 8'h80 | {3'd0, MODE_NA4, 3'b100}, 54'h200);
    check_access(64'h800, 4'd4, KIND_FETCH, PRIV_MACHINE);
    check_access(64'h800, 4'd4, KIND_READ, PRIV_MACHINE);
    check_access(64'h802, 4'd4, KIND_FETCH, 2'd2);
    // All-ones NAPOT covers everything, including an access whose end wraps.
    write_entry(4'd2, {3'd0, MODE_NAPOT, 3'b111}, '1);
    check_access(64'hFFFF_FFFF_FFFF_FFFC, 4'd8, KIND_READ, 2'd0);
    check_access(64'h1000, 4'd0, KIND_WRITE, 2'd0);
    write_entry(4'd2, {3'd0, MODE_OFF, 3'b111}, '1);
    // Locked read-only NAPOT of 32 KiB, then TOR based on it.
    write_entry(4'd3, 8'h80 | {3'd0, MODE_NAPOT, 3'b001}, 54'h1000_0FFF);
    write_entry(4'd4, {3'd0, MODE_TOR, 3'b001}, 54'h1000_4000);
    check_access(64'h4000_0000, 4'd4, KIND_READ, 2'd0);
    check_access(64'h4000_0000, 4'd8, KIND_WRITE, PRIV_MACHINE);
    check_access(64'h4000_7FFC, 4'd8, KIND_AMO, 2'd0);
    check_access(64'h4000_9000, 4'd2, KIND_READ, 2'd1);
    write_entry(4'd15, 8'hFF, '1);
    check_access(64'h8000_0000, 4'd2, KIND_WRITE, 2'd0);
    check_access('1, 4'd1, KIND_FETCH, 2'd2);
    wait_drained();

    first_phase = 1'b1;
    while (items_sent < 1750) begin
      no_idle = ($urandom_range(0, 3) == 0);
      cluster = rand_word() >> $urandom_range(0, 50);
      if ($urandom_range(0, 5) == 0) begin
        for (int k = 0; k < ENTRIES_DEF; k++)
          if ($urandom_range(0, 1) == 0)
            write_entry(4'(k), {3'($urandom), MODE_OFF, 3'($urandom)}, make_word(4'(k)));
      end
      nw = $urandom_range(1, 6);
      repeat (nw) begin
        logic [3:0] idx;
        idx = 4'($urandom);
        write_entry(idx, make_cfg(), make_word(idx));
      end
      nc = $urandom_range(8, 30);
      repeat (nc) begin
        if ($urandom_range(0, 14) == 0)
          drive_item(1'($urandom), 4'($urandom), 8'($urandom), rand_word(), rand_addr(),
                     4'($urandom), 2'($urandom), 2'($urandom));
        else
          check_access(make_access(), make_len(), 2'($urandom), 2'($urandom));
      end
      if (first_phase || $urandom_range(0, 3) == 0) wait_drained();
      first_phase = 1'b0;
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (ENTRIES_DEF + 4) @(negedge clk);
    if (mismatches == 0)
      $display("tb_pmp_access_checker passed");
    else
      $display("tb_pmp_access_checker failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pmp_pkg.sv
sv/pmp_cell.sv
sv/pmp_access_checker.sv
dv/pmp_allow_checker.sv
dv/tb_pmp_access_checker.sv
